// ===== src/lps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel stepper package
// Action and direction codes shared by the line stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

	localparam int unsigned COLOR_BITS = 16;

	typedef logic [1:0] dir_t;

	localparam dir_t DIR_NONE = 2'b00;
	localparam dir_t DIR_UP   = 2'b01;
	localparam dir_t DIR_DOWN = 2'b11;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

endpackage : lps_pkg
`default_nettype wire

// ===== src/line_pixel_stepper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel stepper
// Error-accumulation line rasteriser: load beats set up a line, step beats on
// an active line return one pixel each.
// ----------------------------------------------------------------------------
// One command beat is taken per clock unless stalled. A load beat sets up
// the deltas, directions and error accumulators in the cycle it is accepted
// and gives no pixel. A step beat on an active line produces its pixel in the
// output register on the following edge while the stepper state advances in
// the same cycle, so an unstalled stream of step beats gives one pixel per
// clock. The only stall is a full output register whose pixel is not being
// taken. Step beats on an idle line are consumed without a pixel.
// ----------------------------------------------------------------------------
module line_pixel_stepper #(
	parameter int unsigned COORD_BITS = 10
) (
	input  wire                           clk,
	input  wire                           arst_n,

	input  wire                           cmd_valid,
	output logic                          cmd_ready,
	input  wire                           action,
	input  wire  [COORD_BITS-1:0]         x_start,
	input  wire  [COORD_BITS-1:0]         y_start,
	input  wire  [COORD_BITS-1:0]         x_end,
	input  wire  [COORD_BITS-1:0]         y_end,
	input  wire  [lps_pkg::COLOR_BITS-1:0] pixel_color,

	output logic                          pix_valid,
	input  wire                           pix_ready,
	output logic [COORD_BITS-1:0]         pixel_x,
	output logic [COORD_BITS-1:0]         pixel_y,
	output logic [lps_pkg::COLOR_BITS-1:0] out_color,
	output logic                          last_pixel
);

	localparam int unsigned EW = COORD_BITS + 2;
	localparam int unsigned LW = COORD_BITS + 1;

	logic [COORD_BITS-1:0]          col_q, row_q;
	logic [EW-1:0]                  col_err_q, row_err_q;
	logic [COORD_BITS-1:0]          dx_q, dy_q, span_q;
	lps_pkg::dir_t                  col_dir_q, row_dir_q;
	logic [LW-1:0]                  left_q;
	logic [lps_pkg::COLOR_BITS-1:0] color_q;
	logic                           active_q;
	logic                           pix_valid_q;

	logic                           acc, load_fire, step_fire, is_last;
	logic [COORD_BITS-1:0]          ld_dx, ld_dy, ld_span;
	lps_pkg::dir_t                  ld_col_dir, ld_row_dir;
	logic [EW-1:0]                  col_sum, row_sum, span_ext;
	logic [EW-1:0]                  col_err_nxt, row_err_nxt;
	logic [COORD_BITS-1:0]          col_nxt, row_nxt;

	function automatic logic [COORD_BITS-1:0] axis_move(
		input logic [COORD_BITS-1:0] pos,
		input lps_pkg::dir_t         dir
	);
		logic [COORD_BITS-1:0] res;
		case (dir)
			lps_pkg::DIR_UP:   res = pos + COORD_BITS'(1);
			lps_pkg::DIR_DOWN: res = pos - COORD_BITS'(1);
			default:           res = pos;
		endcase
		return res;
	endfunction

	assign cmd_ready = !pix_valid_q || pix_ready;
	assign acc       = cmd_valid && cmd_ready;
	assign load_fire = acc && (action == lps_pkg::ACT_LOAD);
	assign step_fire = acc && (action == lps_pkg::ACT_STEP) && active_q;
	assign is_last   = (left_q <= LW'(1));

	// load set-up
	always_comb begin
		if (x_end > x_start) begin
			ld_dx      = x_end - x_start;
			ld_col_dir = lps_pkg::DIR_UP;
		end else if (x_end == x_start) begin
			ld_dx      = '0;
			ld_col_dir = lps_pkg::DIR_NONE;
		end else begin
			ld_dx      = x_start - x_end;
			ld_col_dir = lps_pkg::DIR_DOWN;
		end
		if (y_end > y_start) begin
			ld_dy      = y_end - y_start;
			ld_row_dir = lps_pkg::DIR_UP;
		end else if (y_end == y_start) begin
			ld_dy      = '0;
			ld_row_dir = lps_pkg::DIR_NONE;
		end else begin
			ld_dy      = y_start - y_end;
			ld_row_dir = lps_pkg::DIR_DOWN;
		end
		ld_span = (ld_dx > ld_dy) ? ld_dx : ld_dy;
	end

	// error step
	always_comb begin
		span_ext = EW'(span_q);
		col_sum  = col_err_q + EW'(dx_q);
		row_sum  = row_err_q + EW'(dy_q);
		if (col_sum > span_ext) begin
			col_err_nxt = col_sum - span_ext;
			col_nxt     = axis_move(col_q, col_dir_q);
		end else begin
			col_err_nxt = col_sum;
			col_nxt     = col_q;
		end
		if (row_sum > span_ext) begin
			row_err_nxt = row_sum - span_ext;
			row_nxt     = axis_move(row_q, row_dir_q);
		end else begin
			row_err_nxt = row_sum;
			row_nxt     = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			col_err_q <= '0;
			row_err_q <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			span_q    <= '0;
			col_dir_q <= lps_pkg::DIR_NONE;
			row_dir_q <= lps_pkg::DIR_NONE;
			left_q    <= '0;
			color_q   <= '0;
			active_q  <= 1'b0;
		end else if (load_fire) begin
			col_q     <= x_start;
			row_q     <= y_start;
			col_err_q <= '0;
			row_err_q <= '0;
			dx_q      <= ld_dx;
			dy_q      <= ld_dy;
			span_q    <= ld_span;
			col_dir_q <= ld_col_dir;
			row_dir_q <= ld_row_dir;
			left_q    <= LW'(ld_span) + LW'(1);
			color_q   <= pixel_color;
			active_q  <= 1'b1;
		end else if (step_fire) begin
			col_q     <= col_nxt;
			row_q     <= row_nxt;
			col_err_q <= col_err_nxt;
			row_err_q <= row_err_nxt;
			if (is_last) begin
				left_q   <= '0;
				active_q <= 1'b0;
			end else begin
				left_q   <= left_q - LW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (step_fire) begin
			pix_valid_q <= 1'b1;
		end else if (pix_ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			pixel_x    <= col_q;
			pixel_y    <= row_q;
			out_color  <= color_q;
			last_pixel <= is_last;
		end
	end

	assign pix_valid = pix_valid_q;

	a_err_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(col_err_q <= EW'(span_q)) && (row_err_q <= EW'(span_q)))
		else $error("error accumulator above span");

	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (left_q != '0))
		else $error("active line with no pixels left");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step_fire && is_last) |=> !active_q)
		else $error("line still active after last pixel");

	a_load_arms: assert property (@(posedge clk) disable iff (!arst_n)
		load_fire |=> (active_q && (col_err_q == '0) && (row_err_q == '0)))
		else $error("load did not arm the line");

	a_pix_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_valid_q) |-> $past(step_fire))
		else $error("pixel without a step beat");

endmodule : line_pixel_stepper
`default_nettype wire
